// ----- rtl/core/eibd_pkg.sv -----
// ----------------------------------------------------------------------------
// eibd_pkg
// Shared types and constants for the edge interval bit decoder: payload
// words, window register file layout and bit-count codes.
// ----------------------------------------------------------------------------
package eibd_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned BoundW = 16;
    localparam int unsigned IndexW = 7;
    localparam int unsigned NumRegs = 8;
    localparam int unsigned RegIdxW = 3;

    // input word: edge event or rearm command
    typedef struct packed {
        logic              mode;
        logic [TimeW-1:0]  edge_time;
        logic              new_level;
    } t_in_word;

    // output word: one decoded bit
    typedef struct packed {
        logic              bit_value;
        logic [IndexW-1:0] bit_index;
        logic              last_of_edge;
        logic              capture_full;
    } t_out_word;

    // window bounds, all exclusive
    typedef struct packed {
        logic [BoundW-1:0] high_short_min;
        logic [BoundW-1:0] high_short_max;
        logic [BoundW-1:0] high_long_min;
        logic [BoundW-1:0] high_long_max;
        logic [BoundW-1:0] low_short_min;
        logic [BoundW-1:0] low_short_max;
        logic [BoundW-1:0] low_long_min;
        logic [BoundW-1:0] low_long_max;
    } t_windows;

    // register indexes
    localparam logic [RegIdxW-1:0] REG_HIGH_SHORT_MIN = 3'd0;
    localparam logic [RegIdxW-1:0] REG_HIGH_SHORT_MAX = 3'd1;
    localparam logic [RegIdxW-1:0] REG_HIGH_LONG_MIN  = 3'd2;
    localparam logic [RegIdxW-1:0] REG_HIGH_LONG_MAX  = 3'd3;
    localparam logic [RegIdxW-1:0] REG_LOW_SHORT_MIN  = 3'd4;
    localparam logic [RegIdxW-1:0] REG_LOW_SHORT_MAX  = 3'd5;
    localparam logic [RegIdxW-1:0] REG_LOW_LONG_MIN   = 3'd6;
    localparam logic [RegIdxW-1:0] REG_LOW_LONG_MAX   = 3'd7;

    // reset values, microseconds
    localparam logic [BoundW-1:0] RST_HIGH_SHORT_MIN = 16'd20;
    localparam logic [BoundW-1:0] RST_HIGH_SHORT_MAX = 16'd80;
    localparam logic [BoundW-1:0] RST_HIGH_LONG_MIN  = 16'd130;
    localparam logic [BoundW-1:0] RST_HIGH_LONG_MAX  = 16'd175;
    localparam logic [BoundW-1:0] RST_LOW_SHORT_MIN  = 16'd90;
    localparam logic [BoundW-1:0] RST_LOW_SHORT_MAX  = 16'd150;
    localparam logic [BoundW-1:0] RST_LOW_LONG_MIN   = 16'd200;
    localparam logic [BoundW-1:0] RST_LOW_LONG_MAX   = 16'd250;

    // input mode codes
    localparam logic MODE_EDGE  = 1'b0;
    localparam logic MODE_REARM = 1'b1;

    // number of bits an edge yields
    localparam logic [1:0] BITS_NONE = 2'd0;
    localparam logic [1:0] BITS_ONE  = 2'd1;
    localparam logic [1:0] BITS_TWO  = 2'd2;

endpackage

// ----- rtl/core/eibd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// eibd_cfg_regs
// Window bound register file, written one register per word.
// ----------------------------------------------------------------------------
module eibd_cfg_regs
    import eibd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [RegIdxW-1:0] i_wr_index,
    input  logic [BoundW-1:0]  i_wr_data,
    output t_windows           o_windows
);

    t_windows r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.high_short_min <= RST_HIGH_SHORT_MIN;
            r_win.high_short_max <= RST_HIGH_SHORT_MAX;
            r_win.high_long_min  <= RST_HIGH_LONG_MIN;
            r_win.high_long_max  <= RST_HIGH_LONG_MAX;
            r_win.low_short_min  <= RST_LOW_SHORT_MIN;
            r_win.low_short_max  <= RST_LOW_SHORT_MAX;
            r_win.low_long_min   <= RST_LOW_LONG_MIN;
            r_win.low_long_max   <= RST_LOW_LONG_MAX;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_HIGH_SHORT_MIN: r_win.high_short_min <= i_wr_data;
                REG_HIGH_SHORT_MAX: r_win.high_short_max <= i_wr_data;
                REG_HIGH_LONG_MIN:  r_win.high_long_min  <= i_wr_data;
                REG_HIGH_LONG_MAX:  r_win.high_long_max  <= i_wr_data;
                REG_LOW_SHORT_MIN:  r_win.low_short_min  <= i_wr_data;
                REG_LOW_SHORT_MAX:  r_win.low_short_max  <= i_wr_data;
                REG_LOW_LONG_MIN:   r_win.low_long_min   <= i_wr_data;
                REG_LOW_LONG_MAX:   r_win.low_long_max   <= i_wr_data;
                default:            r_win <= r_win;
            endcase
        end
    end

    assign o_windows = r_win;

endmodule

// ----- rtl/core/eibd_classify.sv -----
// ----------------------------------------------------------------------------
// eibd_classify
// Measures the wrapping interval since the previous edge and sorts it into
// the short or long window of the level held during it.
// ----------------------------------------------------------------------------
module eibd_classify
    import eibd_pkg::*;
(
    input  logic [TimeW-1:0] i_edge_time,
    input  logic [TimeW-1:0] i_prev_time,
    input  logic             i_prev_level,
    input  t_windows         i_windows,
    output logic [1:0]       o_nbits
);

    logic [TimeW-1:0]  interval;
    logic [BoundW-1:0] short_min, short_max, long_min, long_max;
    logic              in_short, in_long;

    // modulo 2^32 difference
    assign interval = i_edge_time - i_prev_time;

    always_comb begin
        if (i_prev_level) begin
            short_min = i_windows.high_short_min;
            short_max = i_windows.high_short_max;
            long_min  = i_windows.high_long_min;
            long_max  = i_windows.high_long_max;
        end else begin
            short_min = i_windows.low_short_min;
            short_max = i_windows.low_short_max;
            long_min  = i_windows.low_long_min;
            long_max  = i_windows.low_long_max;
        end
    end

    assign in_short = (interval > {16'd0, short_min}) && (interval < {16'd0, short_max});
    assign in_long  = (interval > {16'd0, long_min})  && (interval < {16'd0, long_max});

    // short window wins on overlap
    always_comb begin
        priority if (in_short) begin
            o_nbits = BITS_ONE;
        end else if (in_long) begin
            o_nbits = BITS_TWO;
        end else begin
            o_nbits = BITS_NONE;
        end
    end

endmodule

// ----- rtl/core/edge_interval_bit_decoder_core.sv -----
// ----------------------------------------------------------------------------
// edge_interval_bit_decoder_core
// Pulse-width bit decoder: edges in, decoded bits with capture index out.
// ----------------------------------------------------------------------------
// path: the first bit of an edge is registered in the output register once its
//   input word sits in the input register and the output slot is free
// throughput: one word per cycle while the output slot is free; an edge yielding
//   two bits holds the input register until its second bit is emitted, since the
//   single output register takes one bit per cycle
// reset: synchronous active low; windows return to their defaults, previous
//   level low, previous time 0, bit count 0, capture armed
// ----------------------------------------------------------------------------
module edge_interval_bit_decoder_core
    import eibd_pkg::*;
#(
    parameter int unsigned CAPTURE_BITS = 128
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_data,
    // output word channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_data,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [RegIdxW-1:0] i_cfg_index,
    input  logic [BoundW-1:0]  i_cfg_data
);

    // bit counter wide enough for CAPTURE_BITS - 1
    localparam int unsigned CountW = $clog2(CAPTURE_BITS + 1);

    // configuration
    t_windows windows;

    assign o_cfg_ready = 1'b1;

    eibd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_windows  (windows)
    );

    // input register
    logic     r_in_valid;
    t_in_word r_in;

    // decoder state
    logic              r_prev_level, n_prev_level;
    logic [TimeW-1:0]  r_prev_time,  n_prev_time;
    logic [CountW-1:0] r_count,      n_count;
    logic              r_armed,      n_armed;
    logic              r_second,     n_second;   // second bit of a double pending

    // output register
    logic      r_out_valid;
    t_out_word r_out;

    logic [1:0]      nbits;
    logic            out_free;
    logic            pop;
    logic            emit;
    logic            emit_last;
    logic            upd_prev;
    logic [CountW:0] count_inc;
    logic            full;
    t_out_word       bit_word;

    eibd_classify u_classify (
        .i_edge_time  (r_in.edge_time),
        .i_prev_time  (r_prev_time),
        .i_prev_level (r_prev_level),
        .i_windows    (windows),
        .o_nbits      (nbits)
    );

    // output slot can take a word this cycle
    assign out_free = !r_out_valid || i_out_ready;

    // capture counting for the bit being emitted
    assign count_inc = {1'b0, r_count} + {{CountW{1'b0}}, 1'b1};
    assign full      = (count_inc >= (CountW + 1)'(CAPTURE_BITS));

    // decide what the head word does this cycle
    always_comb begin
        pop       = 1'b0;
        emit      = 1'b0;
        emit_last = 1'b0;
        n_second  = r_second;
        n_armed   = r_armed;
        if (r_in_valid) begin
            priority if (r_second) begin
                // finish a double bit
                if (out_free) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    pop       = 1'b1;
                    n_second  = 1'b0;
                end
            end else if (r_in.mode == MODE_REARM) begin
                pop     = 1'b1;
                n_armed = 1'b1;
            end else if (!r_armed) begin
                // disarmed: edge dropped without a trace
                pop = 1'b1;
            end else if (nbits == BITS_NONE) begin
                pop = 1'b1;
            end else if (out_free) begin
                emit      = 1'b1;
                emit_last = (nbits == BITS_ONE) || full;
                if (emit_last) begin
                    pop = 1'b1;
                end else begin
                    n_second = 1'b1;
                end
            end
        end
        if (emit && full) begin
            n_armed = 1'b0;
        end
    end

    // bit count wraps to zero on a full capture
    always_comb begin
        n_count = r_count;
        if (emit) begin
            n_count = full ? '0 : count_inc[CountW-1:0];
        end
    end

    // an armed edge records its time and level when it leaves
    assign upd_prev     = pop && (r_in.mode == MODE_EDGE) && r_armed;
    assign n_prev_time  = upd_prev ? r_in.edge_time : r_prev_time;
    assign n_prev_level = upd_prev ? r_in.new_level : r_prev_level;

    always_comb begin
        bit_word.bit_value    = r_prev_level;
        bit_word.bit_index    = IndexW'(r_count);
        bit_word.last_of_edge = emit_last;
        bit_word.capture_full = full;
    end

    assign o_in_ready = !r_in_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prev_level <= 1'b0;
            r_prev_time  <= '0;
            r_count      <= '0;
            r_armed      <= 1'b1;
            r_second     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_prev_level <= n_prev_level;
            r_prev_time  <= n_prev_time;
            r_count      <= n_count;
            r_armed      <= n_armed;
            r_second     <= n_second;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (emit) begin
            r_out <= bit_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a pending second bit always belongs to an armed edge in the input register
    a_second_has_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_in_valid && r_armed && (r_in.mode == MODE_EDGE)))
        else $error("second bit pending without an armed edge");

    // the count never reaches the capture size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} < (CountW + 1)'(CAPTURE_BITS))
        else $error("bit count out of range");

    // a first bit that is not last leaves the second one pending
    a_first_then_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !emit_last) |=> (r_second && r_in_valid))
        else $error("second bit of a double lost");

    // the bit that fills the capture ends its edge and disarms
    a_full_ends_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && full) |=> (!r_armed && r_out.last_of_edge && !r_second))
        else $error("full capture did not close the edge");

endmodule
